// ----- design/fflba_pkg.sv -----
// ----------------------------------------------------------------------------
// fflba_pkg
// Shared types and constants for the first-fit free-list bump allocator.
// ----------------------------------------------------------------------------
package fflba_pkg;

    localparam int ADDR_W     = 48;
    localparam int SIZE_W     = 32;
    localparam int STAT_W     = 2;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 4;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [SIZE_W-1:0] size_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_LIST_FULL = 2'd2
    } status_t;

    // read address = scan index + offset
    typedef enum logic [1:0] {
        RD_OFS_0,
        RD_OFS_1,
        RD_OFS_2
    } rd_ofs_t;

    // register select is paddr[3]
    localparam logic REG_BASE_ADDRESS = 1'b0;
    localparam logic REG_HEAP_SIZE    = 1'b1;

    localparam logic OP_ALLOCATE = 1'b0;
    localparam logic OP_FREE     = 1'b1;

    localparam addr_t BASE_ADDRESS_RESET = '0;
    localparam size_t HEAP_SIZE_RESET    = 32'd65536;

    typedef struct packed {
        addr_t address;
        size_t size;
    } hole_t;

    typedef struct packed {
        logic    load;
        logic    idx_inc;
        rd_ofs_t rd_ofs;
        logic    take;
        logic    shrink;
        logic    tail;
        logic    shift;
        logic    count_dec;
        logic    bump;
        logic    free;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic op_free;
        logic count_zero;
        logic size_eq;
        logic size_gt;
        logic more;
    } stat_t;

endpackage

// ----- design/first_fit_free_list_bump_allocator_unit.sv -----
// Free: the request passes DISPATCH, FREE and DONE; the next beat is accepted in IDLE.
// Allocate: DISPATCH, START, a CHECK per entry scanned, SHIFT while entries move down
// after an exact fit, TAIL after a shrink, BUMP if none fits or the list is empty, DONE;
// the free-list RAM's one read port gives one entry per cycle scanning or compacting.
// A finished result waits in the output register while the next beat is taken.
// aresetn (synchronous) empties the list, zeroes the bump offset, loads defaults.
// ----------------------------------------------------------------------------
// first_fit_free_list_bump_allocator_unit
// First-fit free-list heap allocator with a bump region and APB config port.
// ----------------------------------------------------------------------------
module first_fit_free_list_bump_allocator_unit #(
    parameter int FREE_LIST_DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_operation,
    input  logic [fflba_pkg::SIZE_W-1:0]      s_request_size,
    input  logic [fflba_pkg::ADDR_W-1:0]      s_free_address,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [fflba_pkg::ADDR_W-1:0]      m_granted_address,
    output logic [fflba_pkg::STAT_W-1:0]      m_status,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fflba_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [fflba_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [fflba_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                              pready
);

    import fflba_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    fflba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fflba_dp #(
        .FREE_LIST_DEPTH (FREE_LIST_DEPTH)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_operation       (s_operation),
        .s_request_size    (s_request_size),
        .s_free_address    (s_free_address),
        .m_granted_address (m_granted_address),
        .m_status          (m_status),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

endmodule

// ----- design/fflba_ram.sv -----
// ----------------------------------------------------------------------------
// fflba_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fflba_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/fflba_ctrl.sv -----
// ----------------------------------------------------------------------------
// fflba_ctrl
// Request sequencer: dispatch, first-fit scan, list compaction, bump, free.
// ----------------------------------------------------------------------------
module fflba_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  fflba_pkg::stat_t stat,
    output fflba_pkg::cmd_t  cmd
);

    import fflba_pkg::*;

    typedef enum logic [3:0] {
        IDLE,
        DISPATCH,
        START,
        CHECK,
        SHIFT,
        TAIL,
        BUMP,
        FREE,
        DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = DISPATCH;
                end
            end
            DISPATCH: begin
                if (stat.op_free) begin
                    state_next = FREE;
                end else if (stat.count_zero) begin
                    state_next = BUMP;
                end else begin
                    state_next = START;
                end
            end
            START: begin
                cmd.rd_ofs = RD_OFS_0;
                state_next = CHECK;
            end
            CHECK: begin
                cmd.rd_ofs = RD_OFS_1;
                if (stat.size_eq) begin
                    cmd.take   = 1'b1;
                    state_next = SHIFT;
                end else if (stat.size_gt) begin
                    cmd.shrink = 1'b1;
                    state_next = TAIL;
                end else if (stat.more) begin
                    cmd.idx_inc = 1'b1;
                end else begin
                    state_next = BUMP;
                end
            end
            SHIFT: begin
                cmd.rd_ofs = RD_OFS_2;
                if (stat.more) begin
                    cmd.shift   = 1'b1;
                    cmd.idx_inc = 1'b1;
                end else begin
                    cmd.count_dec = 1'b1;
                    state_next    = DONE;
                end
            end
            TAIL: begin
                cmd.tail   = 1'b1;
                state_next = DONE;
            end
            BUMP: begin
                cmd.bump   = 1'b1;
                state_next = DONE;
            end
            FREE: begin
                cmd.free   = 1'b1;
                state_next = DONE;
            end
            DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    assign m_valid_next = cmd.out_load | (m_valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- design/fflba_dp.sv -----
// ----------------------------------------------------------------------------
// fflba_dp
// Datapath: free-list RAM, hole count, bump offset, config registers, result.
// ----------------------------------------------------------------------------
module fflba_dp #(
    parameter int FREE_LIST_DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  fflba_pkg::cmd_t                   cmd,
    output fflba_pkg::stat_t                  stat,
    input  logic                              s_operation,
    input  logic [fflba_pkg::SIZE_W-1:0]      s_request_size,
    input  logic [fflba_pkg::ADDR_W-1:0]      s_free_address,
    output logic [fflba_pkg::ADDR_W-1:0]      m_granted_address,
    output logic [fflba_pkg::STAT_W-1:0]      m_status,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fflba_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [fflba_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [fflba_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                              pready
);

    import fflba_pkg::*;

    localparam int IDX_W  = (FREE_LIST_DEPTH > 1) ? $clog2(FREE_LIST_DEPTH) : 1;
    localparam int CNT_W  = $clog2(FREE_LIST_DEPTH + 1);
    localparam int HOLE_W = $bits(hole_t);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FREE_LIST_DEPTH);

    addr_t             base_reg;
    size_t             heap_reg;
    logic [CNT_W-1:0]  count_reg;
    size_t             bump_reg;
    logic [CNT_W-1:0]  idx_reg;

    logic              op_reg;
    size_t             req_size_reg;
    addr_t             req_addr_reg;
    addr_t             tail_base_reg;
    size_t             tail_size_reg;
    addr_t             res_addr_reg;
    status_t           res_status_reg;
    addr_t             out_addr_reg;
    status_t           out_status_reg;

    hole_t             rd_hole;
    logic [HOLE_W-1:0] rdata;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    hole_t             wdata;
    logic [CNT_W:0]    rd_sum;
    logic [CNT_W:0]    idx_plus1;
    logic              list_full;
    size_t             new_size;
    logic [SIZE_W:0]   bump_end;
    logic              no_space;
    addr_t             bump_grant;
    logic              cfg_we;

    assign rd_hole   = hole_t'(rdata);
    assign idx_plus1 = {1'b0, idx_reg} + (CNT_W + 1)'(1);
    assign list_full = (count_reg >= DEPTH_CNT);
    assign new_size  = rd_hole.size - req_size_reg;
    assign bump_end  = {1'b0, bump_reg} + {1'b0, req_size_reg};
    assign no_space  = (bump_end > {1'b0, heap_reg});
    assign bump_grant = base_reg + ADDR_W'(bump_reg);

    always_comb begin
        case (cmd.rd_ofs)
            RD_OFS_0: rd_sum = {1'b0, idx_reg};
            RD_OFS_1: rd_sum = {1'b0, idx_reg} + (CNT_W + 1)'(1);
            RD_OFS_2: rd_sum = {1'b0, idx_reg} + (CNT_W + 1)'(2);
            default:  rd_sum = {1'b0, idx_reg};
        endcase
    end

    always_comb begin
        we    = 1'b0;
        waddr = idx_reg[IDX_W-1:0];
        wdata = rd_hole;
        if (cmd.free && !list_full) begin
            we    = 1'b1;
            waddr = count_reg[IDX_W-1:0];
            wdata = '{address: req_addr_reg, size: req_size_reg};
        end else if (cmd.shrink) begin
            we    = 1'b1;
            wdata = '{address: rd_hole.address, size: new_size};
        end else if (cmd.shift) begin
            we    = 1'b1;
        end
    end

    fflba_ram #(
        .WIDTH (HOLE_W),
        .DEPTH (FREE_LIST_DEPTH)
    ) u_hole_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_sum[IDX_W-1:0]),
        .rdata (rdata)
    );

    assign stat.op_free    = op_reg;
    assign stat.count_zero = (count_reg == '0);
    assign stat.size_eq    = (rd_hole.size == req_size_reg);
    assign stat.size_gt    = (rd_hole.size > req_size_reg);
    assign stat.more       = (idx_plus1 < {1'b0, count_reg});

    assign cfg_we = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    always_comb begin
        if (paddr[3] == REG_HEAP_SIZE) begin
            prdata = CFG_DATA_W'(heap_reg);
        end else begin
            prdata = CFG_DATA_W'(base_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= BASE_ADDRESS_RESET;
            heap_reg  <= HEAP_SIZE_RESET;
            count_reg <= '0;
            bump_reg  <= '0;
            idx_reg   <= '0;
        end else begin
            if (cfg_we) begin
                if (paddr[3] == REG_HEAP_SIZE) begin
                    heap_reg <= pwdata[SIZE_W-1:0];
                end else begin
                    base_reg <= pwdata[ADDR_W-1:0];
                end
            end
            if (cmd.free && !list_full) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.count_dec) begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.bump && !no_space) begin
                bump_reg <= bump_end[SIZE_W-1:0];
            end
            if (cmd.load) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_plus1[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= s_operation;
            req_size_reg <= s_request_size;
            req_addr_reg <= s_free_address;
        end
        if (cmd.shrink) begin
            tail_base_reg <= rd_hole.address;
            tail_size_reg <= new_size;
        end
        if (cmd.take) begin
            res_addr_reg   <= rd_hole.address;
            res_status_reg <= ST_OK;
        end else if (cmd.tail) begin
            res_addr_reg   <= tail_base_reg + ADDR_W'(tail_size_reg);
            res_status_reg <= ST_OK;
        end else if (cmd.bump) begin
            res_addr_reg   <= no_space ? '0 : bump_grant;
            res_status_reg <= no_space ? ST_NO_SPACE : ST_OK;
        end else if (cmd.free) begin
            res_addr_reg   <= '0;
            res_status_reg <= list_full ? ST_LIST_FULL : ST_OK;
        end
        if (cmd.out_load) begin
            out_addr_reg   <= res_addr_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_granted_address = out_addr_reg;
    assign m_status          = out_status_reg;

endmodule

// ----- dv/first_fit_free_list_bump_allocator_unit_tb.sv -----
// ----------------------------------------------------------------------------
// first_fit_free_list_bump_allocator_unit_tb
// Self-checking bench for the first-fit allocator: a queue-fed driver with
// bursty traffic, a scoreboard fed by a cycle-free model of the free list and
// bump region, APB register writes between phases, and a stalling receiver.
// ----------------------------------------------------------------------------
module first_fit_free_list_bump_allocator_unit_tb;

    import fflba_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        logic  op;
        size_t size;
        addr_t addr;
    } alloc_req_t;

    typedef struct packed {
        addr_t   addr;
        status_t status;
    } grant_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_operation;
    size_t                 s_request_size;
    addr_t                 s_free_address;
    logic                  m_valid;
    logic                  m_ready;
    addr_t                 m_granted_address;
    logic [STAT_W-1:0]     m_status;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // model state
    addr_t       hole_addr [LIST_DEPTH];
    size_t       hole_sz   [LIST_DEPTH];
    int unsigned hole_cnt;
    size_t       bump_off;
    addr_t       cfg_base;
    size_t       cfg_heap;

    alloc_req_t  req_q[$];
    grant_t      grant_q[$];
    int          err_cnt;
    int          idle_cnt;
    int          burst_left;
    int          gap_left;
    int          rdy_mode;
    int          rdy_cnt;

    first_fit_free_list_bump_allocator_unit #(
        .FREE_LIST_DEPTH(LIST_DEPTH)
    ) i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_request_size    (s_request_size),
        .s_free_address    (s_free_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_granted_address (m_granted_address),
        .m_status          (m_status),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    function automatic grant_t serve_request(logic op, size_t sz, addr_t fa);
        grant_t     g;
        logic       hit;
        logic [32:0] fin;
        int unsigned i;
        int unsigned j;
        g.addr   = '0;
        g.status = ST_OK;
        hit      = 1'b0;
        if (op == OP_FREE) begin
            if (hole_cnt >= LIST_DEPTH) begin
                g.status = ST_LIST_FULL;
            end else begin
                hole_addr[hole_cnt] = fa;
                hole_sz[hole_cnt]   = sz;
                hole_cnt++;
            end
        end else begin
            for (i = 0; i < hole_cnt && !hit; i++) begin
                if (hole_sz[i] == sz) begin
                    g.addr = hole_addr[i];
                    for (j = i; j + 1 < hole_cnt; j++) begin
                        hole_addr[j] = hole_addr[j+1];
                        hole_sz[j]   = hole_sz[j+1];
                    end
                    hole_cnt--;
                    hit = 1'b1;
                end else if (hole_sz[i] > sz) begin
                    hole_sz[i] = hole_sz[i] - sz;
                    g.addr     = hole_addr[i] + addr_t'(hole_sz[i]);
                    hit        = 1'b1;
                end
            end
            if (!hit) begin
                fin = {1'b0, bump_off} + {1'b0, sz};
                if (fin > {1'b0, cfg_heap}) begin
                    g.status = ST_NO_SPACE;
                end else begin
                    g.addr   = cfg_base + addr_t'(bump_off);
                    bump_off = fin[SIZE_W-1:0];
                end
            end
        end
        return g;
    endfunction

    function automatic size_t rand_size();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return size_t'(8 * $urandom_range(0, 8));
        else if (p < 82)
            return size_t'($urandom_range(1, 300));
        else if (p < 95)
            return size_t'($urandom);
        else if (p < 98)
            return '1;
        else
            return '0;
    endfunction

    function automatic size_t heap_above_bump(int unsigned margin);
        logic [32:0] s;
        s = {1'b0, bump_off} + 33'(margin);
        return s[32] ? '1 : s[SIZE_W-1:0];
    endfunction

    task automatic add_req(logic op, size_t sz, addr_t fa);
        alloc_req_t r;
        r.op   = op;
        r.size = sz;
        r.addr = fa;
        req_q.insert(req_q.size(), r);
    endtask

    task automatic add_random(int n, int free_pct);
        int k;
        @(negedge aclk);
        for (k = 0; k < n; k++)
            add_req(($urandom_range(0, 99) < free_pct) ? OP_FREE : OP_ALLOCATE,
                    rand_size(), addr_t'({$urandom, $urandom}));
    endtask

    // hold off new beats until every expected result is back
    task automatic drain();
        do @(posedge aclk); while (req_q.size() != 0 || s_valid || grant_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(logic sel, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 3'b000};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_BASE_ADDRESS)
            cfg_base = val[ADDR_W-1:0];
        else
            cfg_heap = val[SIZE_W-1:0];
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // driver
    always @(posedge aclk) begin : drv
        logic       fire;
        alloc_req_t r;
        if (!aresetn) begin
            s_valid        <= 1'b0;
            s_operation    <= OP_ALLOCATE;
            s_request_size <= '0;
            s_free_address <= '0;
            burst_left     <= $urandom_range(1, 32);
            gap_left       <= 0;
        end else begin
            fire = s_valid && s_ready;
            if (fire)
                grant_q.insert(grant_q.size(),
                               serve_request(s_operation, s_request_size, s_free_address));
            if (!s_valid || fire) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (req_q.size() != 0) begin
                    r = req_q.pop_front();
                    s_operation    <= r.op;
                    s_request_size <= r.size;
                    s_free_address <= r.addr;
                    s_valid        <= 1'b1;
                    if (burst_left <= 1) begin
                        if ($urandom_range(0, 9) == 0) begin
                            burst_left <= 200;
                            gap_left   <= 0;
                        end else begin
                            burst_left <= $urandom_range(1, 32);
                            gap_left   <= $urandom_range(0, 15);
                        end
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rdy_mode <= 0;
            rdy_cnt  <= 0;
        end else begin
            if (rdy_cnt == 0) begin
                rdy_mode <= $urandom_range(0, 3);
                rdy_cnt  <= $urandom_range(50, 400);
            end else begin
                rdy_cnt <= rdy_cnt - 1;
            end
            case (rdy_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_ready <= ($urandom_range(0, 7) == 0);
                end
                default: begin
                    m_ready <= ((rdy_cnt % 24) < 3);
                end
            endcase
        end
    end

    // monitor / scoreboard
    always @(posedge aclk) begin : mon
        grant_t g;
        if (aresetn && m_valid && m_ready) begin
            if (grant_q.size() == 0) begin
                $error("unexpected result beat: granted_address %h, status %0d",
                       m_granted_address, m_status);
                err_cnt++;
            end else begin
                g = grant_q.pop_front();
                if (m_granted_address !== g.addr) begin
                    $error("granted_address mismatch: expected %h, actual %h",
                           g.addr, m_granted_address);
                    err_cnt++;
                end
                if (m_status !== g.status) begin
                    $error("status mismatch: expected %0d, actual %0d", g.status, m_status);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
    end

    initial begin
        wait (idle_cnt >= IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stim
        int k;
        aresetn        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        err_cnt        = 0;
        hole_cnt       = 0;
        bump_off       = '0;
        cfg_base       = BASE_ADDRESS_RESET;
        cfg_heap       = HEAP_SIZE_RESET;
        for (k = 0; k < LIST_DEPTH; k++) begin
            hole_addr[k] = '0;
            hole_sz[k]   = '0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        @(negedge aclk);
        add_req(OP_ALLOCATE, 0, 0);
        add_req(OP_ALLOCATE, 32, 0);
        add_req(OP_FREE, 0, 48'h1000);
        add_req(OP_FREE, 8, 48'h2000);
        add_req(OP_FREE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        add_req(OP_ALLOCATE, 0, 48'hFFFF_FFFF_FFFF);   // zero-size exact fit
        add_req(OP_ALLOCATE, 8, 0);
        add_req(OP_ALLOCATE, 16, 0);                    // shrink, address wraps
        add_req(OP_ALLOCATE, 0, 0);                     // zero size, hole kept
        add_req(OP_ALLOCATE, 32'hFFFF_FFEF, 0);
        add_req(OP_ALLOCATE, 32'hFFFF_FFFF, 0);         // bump overflow
        add_req(OP_ALLOCATE, 65504, 0);                 // fills heap exactly
        add_req(OP_ALLOCATE, 1, 0);
        add_req(OP_ALLOCATE, 0, 0);
        for (k = 0; k <= LIST_DEPTH; k++)
            add_req(OP_FREE, size_t'(8 * (k + 1)), addr_t'(k * 256));
        add_req(OP_ALLOCATE, 8, 0);                     // full compaction
        add_req(OP_ALLOCATE, 128, 0);
        add_random(250, 45);
        drain();

        cfg_write(REG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF);
        cfg_write(REG_HEAP_SIZE, 64'(heap_above_bump(4096)));
        add_random(250, 40);
        drain();

        cfg_write(REG_BASE_ADDRESS, 64'h0);
        cfg_write(REG_HEAP_SIZE, 64'h0);
        add_random(250, 50);
        drain();

        cfg_write(REG_BASE_ADDRESS, 64'({$urandom, $urandom}) & 64'hFFFF_FFFF_FFFF);
        cfg_write(REG_HEAP_SIZE, 64'(heap_above_bump(1024)));
        add_random(250, 45);
        drain();

        cfg_write(REG_BASE_ADDRESS, 64'({$urandom, $urandom}) & 64'hFFFF_FFFF_FFFF);
        cfg_write(REG_HEAP_SIZE, 64'(heap_above_bump(65536)));
        add_random(250, 65);
        drain();

        cfg_write(REG_BASE_ADDRESS, 64'h0);
        cfg_write(REG_HEAP_SIZE, 64'hFFFF_FFFF);
        add_random(250, 30);
        drain();

        repeat (60) @(posedge aclk);
        if (grant_q.size() != 0) begin
            $error("%0d expected results never arrived", grant_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/fflba_pkg.sv
design/fflba_ram.sv
design/fflba_ctrl.sv
design/fflba_dp.sv
design/first_fit_free_list_bump_allocator_unit.sv
dv/first_fit_free_list_bump_allocator_unit_tb.sv
